// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the sphere merge block.
// Depends on nothing; simulation builds see the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`endif
`endif

// ----- src/ses_pkg.sv -----
// Package of the sphere merge block: widths, case codes and the payload structs.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ses_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int ROOT_W      = COORD_WIDTH + 1;   // |difference| and distance
    localparam int SQ_W        = 2 * ROOT_W;        // squared distance, products
    localparam int EPS_WIDTH   = 16;

    localparam logic [1:0] MC_LEFT  = 2'd0;
    localparam logic [1:0] MC_RIGHT = 2'd1;
    localparam logic [1:0] MC_MERGE = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] left_center_x;
        logic signed [COORD_WIDTH-1:0] left_center_y;
        logic signed [COORD_WIDTH-1:0] left_center_z;
        logic        [RAD_WIDTH-1:0]   left_radius;
        logic signed [COORD_WIDTH-1:0] right_center_x;
        logic signed [COORD_WIDTH-1:0] right_center_y;
        logic signed [COORD_WIDTH-1:0] right_center_z;
        logic        [RAD_WIDTH-1:0]   right_radius;
    } t_req;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_center_x;
        logic signed [COORD_WIDTH-1:0] out_center_y;
        logic signed [COORD_WIDTH-1:0] out_center_z;
        logic        [RAD_WIDTH-1:0]   out_radius;
        logic        [1:0]             merge_case;
    } t_rsp;

    // Everything a request carries down the pipeline besides the arithmetic in flight.
    typedef struct packed {
        logic [2:0][COORD_WIDTH-1:0] lc;
        logic [2:0][COORD_WIDTH-1:0] rc;
        logic [RAD_WIDTH-1:0]        lr;
        logic [RAD_WIDTH-1:0]        rr;
        logic [2:0][ROOT_W-1:0]      dmag;
        logic [2:0]                  dneg;
        logic [COORD_WIDTH-1:0]      rd;
        logic                        pick_right;
        logic                        contain;
        logic [ROOT_W-1:0]           span;
        logic [ROOT_W-1:0]           t;
        logic [RAD_WIDTH-1:0]        nr;
    } t_side;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] low;
        logic [ROOT_W-1:0] q;
    } t_div_lane;
endpackage
`default_nettype wire

// ----- src/ses_sqrt_cell.sv -----
// One cell of the square root chain: settles one bit of the root per cycle.
// Depends on ses_pkg.
`default_nettype none
module ses_sqrt_cell
    import ses_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [SQ_W-1:0]   i_x,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic [ROOT_W+1:0] i_rem,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [SQ_W-1:0]        o_x,
    output logic [ROOT_W-1:0]      o_root,
    output logic [ROOT_W+1:0]      o_rem,
    output t_side                  o_side
);
    logic              r_valid;
    logic [SQ_W-1:0]   r_x;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+1:0] r_rem;
    t_side             r_side;
    logic [ROOT_W+2:0] w_cur;
    logic [ROOT_W+2:0] w_trial;
    logic              w_ge;

    // The remainder never exceeds twice the root, so its top bit is always clear.
    always_comb begin
        w_cur   = {i_rem[ROOT_W:0], i_x[SQ_W-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_ge    = (w_cur >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_x    <= {i_x[SQ_W-3:0], 2'b00};
        r_root <= {i_root[ROOT_W-2:0], w_ge};
        r_rem  <= w_ge ? (w_cur[ROOT_W+1:0] - w_trial[ROOT_W+1:0]) : w_cur[ROOT_W+1:0];
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_root  = r_root;
    assign o_rem   = r_rem;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ----- src/ses_div_cell.sv -----
// One cell of the divide chain: one quotient bit for each of the three axes.
// Depends on ses_pkg; the divisor is the distance carried in the side data.
`default_nettype none
module ses_div_cell
    import ses_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire t_div_lane [2:0] i_lane,
    input  wire t_side           i_side,
    output logic                 o_valid,
    output t_div_lane [2:0]      o_lane,
    output t_side                o_side
);
    logic            r_valid;
    t_div_lane [2:0] r_lane;
    t_side           r_side;
    t_div_lane [2:0] n_lane;
    logic [ROOT_W:0] w_cur [3];
    logic [ROOT_W:0] w_den;
    logic [2:0]      w_ge;

    always_comb begin
        w_den = {1'b0, i_side.span};
        for (int k = 0; k < 3; k++) begin
            w_cur[k]        = {i_lane[k].rem, i_lane[k].low[ROOT_W-1]};
            w_ge[k]         = (w_cur[k] >= w_den);
            n_lane[k].rem   = w_ge[k] ? ROOT_W'(w_cur[k] - w_den) : w_cur[k][ROOT_W-1:0];
            n_lane[k].low   = {i_lane[k].low[ROOT_W-2:0], 1'b0};
            n_lane[k].q     = {i_lane[k].q[ROOT_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_lane <= n_lane;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_side  = r_side;
endmodule
`default_nettype wire

// ----- src/sphere_enclosing_spheres.sv -----
// Top level of the sphere merge block: front end, the two cell chains and the output stage.
// Depends on ses_pkg, ses_sqrt_cell, ses_div_cell and assert_macros.svh.
//
// Takes one pair of spheres per clock and returns the smallest enclosing sphere through
// four front stages (request register, differences and squares, sum, containment test),
// 33 square root cells, two stages for radius and products, 33 divide cells and the
// output register. busy stays low, so a request may be given every cycle;
// o_done marks each result for one cycle and the receiver cannot stall it. Write the
// epsilon register only while no request is in flight.
`default_nettype none
`include "assert_macros.svh"
module sphere_enclosing_spheres
    import ses_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_req                 i_req,
    output logic                      o_done,
    output t_rsp                      o_rsp,
    input  wire logic                 i_cfg_we,
    input  wire logic [EPS_WIDTH-1:0] i_cfg_wdata
);
    localparam int LATENCY = 4 + 2 * ROOT_W + 3;
    localparam logic [RAD_WIDTH-1:0] RAD_MAX = {RAD_WIDTH{1'b1}};

    logic [EPS_WIDTH-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // Stage 0: register the request.
    logic r_v0;
    t_req r_req0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_req0 <= i_req;
    end

    // Stage 1: differences and their squares.
    t_side                      n_side1;
    logic signed [ROOT_W-1:0]   w_d [3];
    logic signed [COORD_WIDTH-1:0] w_rd;
    logic [RAD_WIDTH-1:0]       w_rdmag;
    always_comb begin
        n_side1    = '0;
        n_side1.lc = {r_req0.left_center_z, r_req0.left_center_y, r_req0.left_center_x};
        n_side1.rc = {r_req0.right_center_z, r_req0.right_center_y, r_req0.right_center_x};
        n_side1.lr = r_req0.left_radius;
        n_side1.rr = r_req0.right_radius;
        for (int k = 0; k < 3; k++) begin
            w_d[k] = $signed({n_side1.rc[k][COORD_WIDTH-1], n_side1.rc[k]})
                   - $signed({n_side1.lc[k][COORD_WIDTH-1], n_side1.lc[k]});
            n_side1.dneg[k] = w_d[k][ROOT_W-1];
            n_side1.dmag[k] = w_d[k][ROOT_W-1] ? ROOT_W'(-w_d[k]) : ROOT_W'(w_d[k]);
        end
        w_rd    = $signed({1'b0, r_req0.right_radius}) - $signed({1'b0, r_req0.left_radius});
        w_rdmag = w_rd[COORD_WIDTH-1] ? RAD_WIDTH'(-w_rd) : RAD_WIDTH'(w_rd);
        n_side1.rd = w_rd;
        n_side1.pick_right = (r_req0.right_radius > r_req0.left_radius);
    end

    logic            r_v1;
    t_side           r_side1;
    logic [SQ_W-1:0] r_sq1 [3];
    logic [SQ_W-1:0] r_rdsq1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_side1 <= n_side1;
        for (int k = 0; k < 3; k++) begin
            r_sq1[k] <= SQ_W'(n_side1.dmag[k]) * SQ_W'(n_side1.dmag[k]);
        end
        r_rdsq1 <= SQ_W'(w_rdmag) * SQ_W'(w_rdmag);
    end

    // Stage 2: squared distance.
    logic            r_v2;
    t_side           r_side2;
    logic [SQ_W-1:0] r_d2_2;
    logic [SQ_W-1:0] r_rdsq2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_side2 <= r_side1;
        r_d2_2  <= r_sq1[0] + r_sq1[1] + r_sq1[2];
        r_rdsq2 <= r_rdsq1;
    end

    // Stage 3: containment test; ties count as containment.
    logic            r_v3;
    t_side           r_side3;
    t_side           n_side3;
    logic [SQ_W-1:0] r_d2_3;
    always_comb begin
        n_side3         = r_side2;
        n_side3.contain = (r_d2_2 <= r_rdsq2);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_side3 <= n_side3;
        r_d2_3  <= r_d2_2;
    end

    // Square root chain, most significant root bit first.
    logic              w_sq_v    [ROOT_W+1];
    logic [SQ_W-1:0]   w_sq_x    [ROOT_W+1];
    logic [ROOT_W-1:0] w_sq_root [ROOT_W+1];
    logic [ROOT_W+1:0] w_sq_rem  [ROOT_W+1];
    t_side             w_sq_side [ROOT_W+1];

    assign w_sq_v[0]    = r_v3;
    assign w_sq_x[0]    = r_d2_3;
    assign w_sq_root[0] = '0;
    assign w_sq_rem[0]  = '0;
    assign w_sq_side[0] = r_side3;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        ses_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_v[g]),
            .i_x     (w_sq_x[g]),
            .i_root  (w_sq_root[g]),
            .i_rem   (w_sq_rem[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_v[g+1]),
            .o_x     (w_sq_x[g+1]),
            .o_root  (w_sq_root[g+1]),
            .o_rem   (w_sq_rem[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // Post stage: new radius and the scaled half length of the shift.
    t_side               n_side_p;
    logic [ROOT_W:0]     w_nr_sum;
    logic [ROOT_W-1:0]   w_nr_half;
    logic signed [ROOT_W+1:0] w_t_sum;
    always_comb begin
        n_side_p      = w_sq_side[ROOT_W];
        n_side_p.span = w_sq_root[ROOT_W];
        w_nr_sum  = (ROOT_W+1)'(w_sq_root[ROOT_W]) + (ROOT_W+1)'(n_side_p.lr)
                  + (ROOT_W+1)'(n_side_p.rr);
        w_nr_half = w_nr_sum[ROOT_W:1];
        n_side_p.nr = (w_nr_half > ROOT_W'(RAD_MAX)) ? RAD_MAX : w_nr_half[RAD_WIDTH-1:0];
        w_t_sum   = $signed({2'b00, w_sq_root[ROOT_W]})
                  + $signed({{3{n_side_p.rd[COORD_WIDTH-1]}}, n_side_p.rd});
        n_side_p.t = w_t_sum[ROOT_W:1];
    end

    logic  r_vp;
    t_side r_side_p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else begin
            r_vp <= w_sq_v[ROOT_W];
        end
        r_side_p <= n_side_p;
    end

    // Product stage: |d| times the half length, one multiplier per axis.
    logic            r_vm;
    t_side           r_side_m;
    logic [SQ_W-1:0] r_prod [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_vp;
        end
        r_side_m <= r_side_p;
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= SQ_W'(r_side_p.dmag[k]) * SQ_W'(r_side_p.t);
        end
    end

    // Divide chain. The quotient fits the root width, so the upper half of the
    // product is already below the divisor and serves as the first remainder.
    logic            w_dv_v    [ROOT_W+1];
    t_div_lane [2:0] w_dv_lane [ROOT_W+1];
    t_side           w_dv_side [ROOT_W+1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dv_lane[0][k].rem = r_prod[k][SQ_W-1:ROOT_W];
            w_dv_lane[0][k].low = r_prod[k][ROOT_W-1:0];
            w_dv_lane[0][k].q   = '0;
        end
    end
    assign w_dv_v[0]    = r_vm;
    assign w_dv_side[0] = r_side_m;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_div
        ses_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv_v[g]),
            .i_lane  (w_dv_lane[g]),
            .i_side  (w_dv_side[g]),
            .o_valid (w_dv_v[g+1]),
            .o_lane  (w_dv_lane[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    // Output stage: apply the shift, saturate, and pick the case.
    t_side                    w_fs;
    t_rsp                     n_rsp;
    logic [2:0][COORD_WIDTH-1:0] w_cen;
    logic signed [ROOT_W+1:0] w_c [3];
    logic                     w_shift;
    always_comb begin
        w_fs    = w_dv_side[ROOT_W];
        w_shift = (w_fs.span > ROOT_W'(r_eps));
        for (int k = 0; k < 3; k++) begin
            if (w_fs.dneg[k]) begin
                w_c[k] = $signed({{3{w_fs.lc[k][COORD_WIDTH-1]}}, w_fs.lc[k]})
                       - $signed({2'b00, w_dv_lane[ROOT_W][k].q});
            end else begin
                w_c[k] = $signed({{3{w_fs.lc[k][COORD_WIDTH-1]}}, w_fs.lc[k]})
                       + $signed({2'b00, w_dv_lane[ROOT_W][k].q});
            end
            if (w_fs.contain) begin
                w_cen[k] = w_fs.pick_right ? w_fs.rc[k] : w_fs.lc[k];
            end else if (!w_shift) begin
                w_cen[k] = w_fs.lc[k];
            end else if (w_c[k][ROOT_W+1:COORD_WIDTH-1] == '0
                         || w_c[k][ROOT_W+1:COORD_WIDTH-1] == '1) begin
                w_cen[k] = w_c[k][COORD_WIDTH-1:0];
            end else if (w_c[k][ROOT_W+1]) begin
                w_cen[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
                w_cen[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
        n_rsp.out_center_x = w_cen[0];
        n_rsp.out_center_y = w_cen[1];
        n_rsp.out_center_z = w_cen[2];
        if (w_fs.contain) begin
            n_rsp.out_radius = w_fs.pick_right ? w_fs.rr : w_fs.lr;
            n_rsp.merge_case = w_fs.pick_right ? MC_RIGHT : MC_LEFT;
        end else begin
            n_rsp.out_radius = w_fs.nr;
            n_rsp.merge_case = MC_MERGE;
        end
    end

    logic r_done;
    t_rsp r_rsp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_dv_v[ROOT_W];
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `ASSERT_IMPLY(a_case_legal, i_clk, i_rst_n, o_done,
        o_rsp.merge_case == MC_LEFT || o_rsp.merge_case == MC_RIGHT
        || o_rsp.merge_case == MC_MERGE)
    `ASSERT_IMPLY(a_fixed_latency, i_clk, i_rst_n, start, ##LATENCY o_done)
    `ASSERT_IMPLY(a_contain_radius, i_clk, i_rst_n,
        o_done && o_rsp.merge_case == MC_RIGHT, o_rsp.out_radius != '0)
endmodule
`default_nettype wire
